// ===== design/sdti_pkg.sv =====
package sdti_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [PADDR_W-3:0] REG_DEFAULT_VALUE = '0;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_INT   = 3'd2,
        PH_FRAC  = 3'd3,
        PH_TRAIL = 3'd4,
        PH_BAD   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     parsed_ok;
        logic                     overflowed;
    } out_item_t;

endpackage

// ===== design/sdti_if.sv =====
interface sdti_in_if;
    logic               valid;
    logic               ready;
    sdti_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sdti_out_if;
    logic                valid;
    logic                ready;
    sdti_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/strict_decimal_text_to_integer.sv =====
// channel  | dir | payload                              | handshake
// ---------+-----+--------------------------------------+-------------
// text     | in  | char_code[7:0]                       | valid/ready
// result   | out | value[31:0] s, parsed_ok, overflowed | valid/ready
// apb      | in  | default_value at byte address 0      | psel/penable
//
// One byte per cycle: a byte is registered, then updates the parse state in
// the next cycle (a times-ten multiply and a 36-bit add), and a zero byte
// loads the result register. Reset returns the parser to the leading space
// phase and clears default_value. A held result stalls only a following
// zero byte.
module strict_decimal_text_to_integer (
    input  logic                          clk,
    input  logic                          rst_n,
    sdti_in_if.sink                       text,
    sdti_out_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdti_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdti_pkg::DATA_W-1:0]   pwdata,
    output logic [sdti_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned W  = sdti_pkg::DATA_W;
    localparam int unsigned MW = W + 4;

    logic                     stg_valid_reg;
    logic                     stg_valid_next;
    logic [7:0]               stg_char_reg;
    sdti_pkg::phase_t         phase_reg;
    sdti_pkg::phase_t         phase_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic [W-1:0]             acc_reg;
    logic [W-1:0]             acc_next;
    logic                     ovf_reg;
    logic                     ovf_next;
    logic signed [W-1:0]      default_value_reg;
    logic                     out_valid_reg;
    sdti_pkg::out_item_t      out_data_reg;
    sdti_pkg::out_item_t      out_data_next;

    logic                     term;
    logic                     advance;
    logic                     num_char;
    logic [MW-1:0]            acc_mul;
    logic [W-1:0]             mag_neg;
    logic                     ok_end;
    logic                     range_ovf;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign prdata    = default_value_reg;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[sdti_pkg::PADDR_W-1:2] == sdti_pkg::REG_DEFAULT_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_value_reg <= '0;
        end
        else if (cfg_write)
        begin
            default_value_reg <= $signed(pwdata);
        end
    end

    assign term       = (stg_char_reg == sdti_pkg::CH_NUL);
    assign advance    = stg_valid_reg && (!term || !out_valid_reg || result.ready);
    assign text.ready = !stg_valid_reg || advance;
    assign stg_valid_next = text.ready ? text.valid : stg_valid_reg;

    // hold the byte stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            stg_char_reg <= text.data.char_code;
        end
    end

    assign num_char = (stg_char_reg >= sdti_pkg::CH_ZERO)
                      && (stg_char_reg <= sdti_pkg::CH_NINE);
    assign acc_mul  = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                      + {{(MW-4){1'b0}}, stg_char_reg[3:0]};
    assign mag_neg  = '0 - acc_reg;
    assign ok_end   = (phase_reg == sdti_pkg::PH_INT) || (phase_reg == sdti_pkg::PH_FRAC)
                      || (phase_reg == sdti_pkg::PH_TRAIL);
    assign range_ovf = neg_reg ? (acc_reg > {1'b1, {(W-1){1'b0}}}) : acc_reg[W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sdti_pkg::PH_LEAD;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        if (advance)
        begin
            if (term)
            begin
                phase_next = sdti_pkg::PH_LEAD;
                neg_next   = 1'b0;
                acc_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    sdti_pkg::PH_LEAD:
                    begin
                        if (stg_char_reg == sdti_pkg::CH_SPACE)
                        begin
                            phase_next = sdti_pkg::PH_LEAD;
                        end
                        else if (stg_char_reg == sdti_pkg::CH_MINUS)
                        begin
                            neg_next   = 1'b1;
                            phase_next = sdti_pkg::PH_SIGN;
                        end
                        else if (stg_char_reg == sdti_pkg::CH_PLUS)
                        begin
                            phase_next = sdti_pkg::PH_SIGN;
                        end
                        else if (num_char)
                        begin
                            acc_next   = acc_mul[W-1:0];
                            ovf_next   = ovf_reg || (acc_mul[MW-1:W] != '0);
                            phase_next = sdti_pkg::PH_INT;
                        end
                        else
                        begin
                            phase_next = sdti_pkg::PH_BAD;
                        end
                    end
                    sdti_pkg::PH_SIGN:
                    begin
                        if (num_char)
                        begin
                            acc_next   = acc_mul[W-1:0];
                            ovf_next   = ovf_reg || (acc_mul[MW-1:W] != '0);
                            phase_next = sdti_pkg::PH_INT;
                        end
                        else
                        begin
                            phase_next = sdti_pkg::PH_BAD;
                        end
                    end
                    sdti_pkg::PH_INT:
                    begin
                        if (num_char)
                        begin
                            acc_next = acc_mul[W-1:0];
                            ovf_next = ovf_reg || (acc_mul[MW-1:W] != '0);
                        end
                        else if (stg_char_reg == sdti_pkg::CH_POINT)
                        begin
                            phase_next = sdti_pkg::PH_FRAC;
                        end
                        else if (stg_char_reg == sdti_pkg::CH_SPACE)
                        begin
                            phase_next = sdti_pkg::PH_TRAIL;
                        end
                        else
                        begin
                            phase_next = sdti_pkg::PH_BAD;
                        end
                    end
                    sdti_pkg::PH_FRAC:
                    begin
                        if (stg_char_reg == sdti_pkg::CH_SPACE)
                        begin
                            phase_next = sdti_pkg::PH_TRAIL;
                        end
                        else if (!num_char)
                        begin
                            phase_next = sdti_pkg::PH_BAD;
                        end
                    end
                    sdti_pkg::PH_TRAIL:
                    begin
                        if (stg_char_reg != sdti_pkg::CH_SPACE)
                        begin
                            phase_next = sdti_pkg::PH_BAD;
                        end
                    end
                    default:
                    begin
                        phase_next = sdti_pkg::PH_BAD;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        if (ok_end)
        begin
            out_data_next.value      = $signed(neg_reg ? mag_neg : acc_reg);
            out_data_next.parsed_ok  = 1'b1;
            out_data_next.overflowed = ovf_reg || range_ovf;
        end
        else
        begin
            out_data_next.value      = default_value_reg;
            out_data_next.parsed_ok  = 1'b0;
            out_data_next.overflowed = 1'b0;
        end
    end

    // load the result on a terminating byte, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && term)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    a_fail_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.parsed_ok |-> !result.data.overflowed)
        else $error("default result carries overflow");

    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && term |=> (phase_reg == sdti_pkg::PH_LEAD) && (acc_reg == '0)
                            && !neg_reg && !ovf_reg)
        else $error("parse state not cleared after terminator");

    a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && term |=> result.valid)
        else $error("terminator gave no result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text.ready |-> stg_valid_reg && term && out_valid_reg && !result.ready)
        else $error("input stalled without a held result");

endmodule

// ===== tb/testbench.sv =====
module testbench;

    localparam logic [0:0] REG_UNMAPPED = 1'b1;
    localparam logic [sdti_pkg::PADDR_W-1:0] ADDR_DEFAULT =
        {sdti_pkg::REG_DEFAULT_VALUE, 2'b00};
    localparam logic [sdti_pkg::PADDR_W-1:0] ADDR_UNMAPPED = {REG_UNMAPPED, 2'b00};
    localparam int PHASE_COUNT = 5;
    localparam int CHARS_PER_PHASE = 330;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [sdti_pkg::PADDR_W-1:0] paddr;
    logic [sdti_pkg::DATA_W-1:0] pwdata;
    logic [sdti_pkg::DATA_W-1:0] prdata;
    logic pready;

    sdti_in_if text_ch ();
    sdti_out_if result_ch ();

    strict_decimal_text_to_integer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0] pending_chars[$];
    sdti_pkg::out_item_t expected_results[$];
    int mismatches = 0;
    bit idle_on = 1'b1;
    bit text_fired = 1'b0;
    int text_gap = 0;
    int result_gap = 0;

    // shadow of the parser and of default_value
    sdti_pkg::phase_t parse_ph = sdti_pkg::PH_LEAD;
    logic neg_sign = 1'b0;
    logic [31:0] magnitude = '0;
    logic wrapped = 1'b0;
    logic [31:0] dflt_value = '0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] grown;
        grown = {32'd0, magnitude} * 64'd10 + 64'(c - sdti_pkg::CH_ZERO);
        if (grown > 64'h0000_0000_FFFF_FFFF)
            wrapped = 1'b1;
        magnitude = grown[31:0];
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        logic digit;
        sdti_pkg::out_item_t r;
        digit = (c >= sdti_pkg::CH_ZERO) && (c <= sdti_pkg::CH_NINE);
        if (c == sdti_pkg::CH_NUL)
        begin
            if (parse_ph inside {sdti_pkg::PH_INT, sdti_pkg::PH_FRAC, sdti_pkg::PH_TRAIL})
            begin
                r.value      = neg_sign ? 32'(32'd0 - magnitude) : magnitude;
                r.parsed_ok  = 1'b1;
                r.overflowed = wrapped || (neg_sign ? (magnitude > 32'h8000_0000)
                                                    : (magnitude > 32'h7FFF_FFFF));
            end
            else
            begin
                r.value      = dflt_value;
                r.parsed_ok  = 1'b0;
                r.overflowed = 1'b0;
            end
            expected_results.push_back(r);
            parse_ph  = sdti_pkg::PH_LEAD;
            neg_sign  = 1'b0;
            magnitude = '0;
            wrapped   = 1'b0;
            return;
        end
        case (parse_ph)
            sdti_pkg::PH_LEAD:
            begin
                if (c == sdti_pkg::CH_SPACE)
                    parse_ph = sdti_pkg::PH_LEAD;
                else if (c == sdti_pkg::CH_MINUS)
                begin
                    neg_sign = 1'b1;
                    parse_ph = sdti_pkg::PH_SIGN;
                end
                else if (c == sdti_pkg::CH_PLUS)
                    parse_ph = sdti_pkg::PH_SIGN;
                else if (digit)
                begin
                    add_digit(c);
                    parse_ph = sdti_pkg::PH_INT;
                end
                else
                    parse_ph = sdti_pkg::PH_BAD;
            end
            sdti_pkg::PH_SIGN:
            begin
                if (digit)
                begin
                    add_digit(c);
                    parse_ph = sdti_pkg::PH_INT;
                end
                else
                    parse_ph = sdti_pkg::PH_BAD;
            end
            sdti_pkg::PH_INT:
            begin
                if (digit)
                    add_digit(c);
                else if (c == sdti_pkg::CH_POINT)
                    parse_ph = sdti_pkg::PH_FRAC;
                else if (c == sdti_pkg::CH_SPACE)
                    parse_ph = sdti_pkg::PH_TRAIL;
                else
                    parse_ph = sdti_pkg::PH_BAD;
            end
            sdti_pkg::PH_FRAC:
            begin
                if (c == sdti_pkg::CH_SPACE)
                    parse_ph = sdti_pkg::PH_TRAIL;
                else if (!digit)
                    parse_ph = sdti_pkg::PH_BAD;
            end
            sdti_pkg::PH_TRAIL:
            begin
                if (c != sdti_pkg::CH_SPACE)
                    parse_ph = sdti_pkg::PH_BAD;
            end
            default:
                parse_ph = sdti_pkg::PH_BAD;
        endcase
    endfunction

    // text driver
    always @(negedge clk)
    begin
        if (!text_ch.valid || text_fired)
        begin
            if (text_gap > 0)
            begin
                text_gap--;
                text_ch.valid <= 1'b0;
            end
            else if (pending_chars.size() == 0)
                text_ch.valid <= 1'b0;
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                text_gap = $urandom_range(1, 8) - 1;
                text_ch.valid <= 1'b0;
            end
            else
            begin
                text_ch.valid <= 1'b1;
                text_ch.data.char_code <= pending_chars[0];
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (result_gap > 0)
        begin
            result_gap--;
            result_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 11) == 0)
        begin
            result_gap = $urandom_range(1, 8) - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        sdti_pkg::out_item_t want;
        sdti_pkg::out_item_t got;
        if (rst_n)
        begin
            text_fired <= text_ch.valid && text_ch.ready;
            if (text_ch.valid && text_ch.ready)
            begin
                parse_byte(text_ch.data.char_code);
                void'(pending_chars.pop_front());
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result value", '0, got.value);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", want.value, got.value);
                    if (got.parsed_ok !== want.parsed_ok)
                        report_mismatch("parsed_ok", 32'(want.parsed_ok),
                                        32'(got.parsed_ok));
                    if (got.overflowed !== want.overflowed)
                        report_mismatch("overflowed", 32'(want.overflowed),
                                        32'(got.overflowed));
                end
            end
        end
    end

    task automatic apb_write(input logic [sdti_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_DEFAULT)
            dflt_value = data;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_default();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DEFAULT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== dflt_value)
            report_mismatch("default_value readback", dflt_value, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(s[i]);
    endtask

    task automatic queue_random_string();
        logic [7:0] txt[$];
        longint unsigned specials[8];
        string num;
        int kind;
        int pos;
        specials = '{64'd0, 64'd1, 64'd2147483647, 64'd2147483648, 64'd2147483649,
                     64'd4294967295, 64'd4294967296, 64'd99999999999};
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            repeat ($urandom_range(0, 6))
                txt.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                txt.push_back(sdti_pkg::CH_SPACE);
            case ($urandom_range(0, 2))
                1: txt.push_back(sdti_pkg::CH_MINUS);
                2: txt.push_back(sdti_pkg::CH_PLUS);
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                num = $sformatf("%0d", specials[$urandom_range(0, 7)]);
                for (int i = 0; i < num.len(); i++)
                    txt.push_back(num[i]);
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    txt.push_back(sdti_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                txt.push_back(sdti_pkg::CH_POINT);
                repeat ($urandom_range(0, 3))
                    txt.push_back(sdti_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2))
                txt.push_back(sdti_pkg::CH_SPACE);
            if (kind >= 7)
            begin
                pos = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: txt.insert(pos, 8'($urandom_range(1, 255)));
                    1: txt[pos] = 8'($urandom_range(1, 255));
                    default:
                        while (txt.size() > pos)
                            void'(txt.pop_back());
                endcase
            end
        end
        foreach (txt[i])
            pending_chars.push_back(txt[i]);
        pending_chars.push_back(sdti_pkg::CH_NUL);
    endtask

    initial
    begin
        logic [31:0] defaults[PHASE_COUNT];
        int start;
        text_ch.valid          = 1'b0;
        text_ch.data.char_code = '0;
        result_ch.ready        = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        defaults = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_default();
        pending_chars.push_back(sdti_pkg::CH_NUL);
        pending_chars.push_back(sdti_pkg::CH_MINUS);
        pending_chars.push_back(sdti_pkg::CH_NUL);
        queue_text("+9.");
        pending_chars.push_back(sdti_pkg::CH_NUL);
        queue_text(" 0x");
        pending_chars.push_back(sdti_pkg::CH_NUL);
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(sdti_pkg::CH_NUL);
        queue_text("7 7");
        pending_chars.push_back(sdti_pkg::CH_NUL);
        drain();

        // writes to an unmapped register leave default_value alone
        apb_write(ADDR_UNMAPPED, 32'h1234_5678);
        check_default();

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            apb_write(ADDR_DEFAULT, defaults[ph]);
            check_default();
            idle_on = (ph != 2) && (ph != PHASE_COUNT - 1);
            start = 0;
            while (start < CHARS_PER_PHASE)
            begin
                queue_random_string();
                start = pending_chars.size();
            end
            drain();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sdti_pkg.sv
design/sdti_if.sv
design/strict_decimal_text_to_integer.sv
tb/testbench.sv
